// ===== rtl/hpt_pkg.sv =====
package hpt_pkg;

    // item field widths
    localparam int CoordW  = 32;
    localparam int CoefW   = 32;
    localparam int RegW    = 64;
    localparam int NumRegs = 8;
    localparam int IdxW    = 4;

    // arithmetic widths
    localparam int ProdW  = 2 * CoefW;
    localparam int FracW  = 16;
    localparam int SumW   = 50;
    localparam int MagW   = SumW;
    localparam int NumW   = MagW + FracW;
    localparam int QuoW   = CoordW + 1;
    localparam int TrialW = NumW + QuoW - 1 - FracW + FracW;

    // pipeline depth
    localparam int MulLen = 2;
    localparam int DivLen = QuoW + 2;
    localparam int NumStg = MulLen + DivLen;

    // identity reset values of the matrix registers
    localparam logic [RegW-1:0] OneLo = 64'h0000_0000_0001_0000;
    localparam logic [RegW-1:0] OneHi = 64'h0001_0000_0000_0000;

    typedef logic [NumRegs-1:0][RegW-1:0] mat_t;
    typedef logic signed [SumW-1:0] sum_t;

    // whole matrix at reset, register 7 first
    localparam mat_t MatIdent = {OneHi, RegW'(0), OneLo, RegW'(0),
                                 RegW'(0), OneHi, RegW'(0), OneLo};

    // control handed from the top to the dot-product unit and the divider lanes
    typedef struct packed {
        logic [MulLen-1:0] mul_en;
        logic [DivLen-1:0] div_en;
    } stg_en_t;

endpackage

// ===== rtl/hpt_dot.sv =====
module hpt_dot (
    input  logic                                aclk,
    input  logic [hpt_pkg::MulLen-1:0]          en,
    input  hpt_pkg::mat_t                       mat,
    input  logic signed [hpt_pkg::CoordW-1:0]   px,
    input  logic signed [hpt_pkg::CoordW-1:0]   py,
    input  logic signed [hpt_pkg::CoordW-1:0]   pz,
    output hpt_pkg::sum_t                       sum_x,
    output hpt_pkg::sum_t                       sum_y,
    output hpt_pkg::sum_t                       sum_z,
    output hpt_pkg::sum_t                       sum_w
);

    logic signed [hpt_pkg::ProdW-1:0] prod_reg [4][3];
    hpt_pkg::sum_t                    sum_reg  [4];
    hpt_pkg::sum_t                    sum_next [4];
    logic signed [hpt_pkg::CoordW-1:0] pt [3];

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    // stage 0: twelve coefficient by coordinate products
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= $signed(mat[r*2 + c/2][(c%2)*hpt_pkg::CoefW +:
                                        hpt_pkg::CoefW]) * pt[c];
                end
            end
        end
    end

    // stage 1: floor each product to q16.16 and add the translation column
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sum_next[r] = hpt_pkg::SumW'($signed(mat[r*2 + 1][hpt_pkg::RegW-1 -:
                            hpt_pkg::CoefW]));
            for (int c = 0; c < 3; c++) begin
                sum_next[r] = sum_next[r] + hpt_pkg::SumW'(prod_reg[r][c] >>>
                                hpt_pkg::FracW);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int r = 0; r < 4; r++) begin
                sum_reg[r] <= sum_next[r];
            end
        end
    end

    assign sum_x = sum_reg[0];
    assign sum_y = sum_reg[1];
    assign sum_z = sum_reg[2];
    assign sum_w = sum_reg[3];

endmodule

// ===== rtl/hpt_div.sv =====
module hpt_div (
    input  logic                                aclk,
    input  logic [hpt_pkg::DivLen-1:0]          en,
    input  hpt_pkg::sum_t                       num,
    input  hpt_pkg::sum_t                       den,
    output logic [hpt_pkg::CoordW-1:0]          quo,
    output logic                                sat,
    output logic                                wz
);

    localparam int Steps = hpt_pkg::QuoW;
    localparam int RemW  = hpt_pkg::NumW;
    localparam int DenW  = hpt_pkg::MagW;
    localparam int CmpW  = RemW + Steps - 1 - hpt_pkg::FracW + hpt_pkg::FracW;
    localparam int PreW  = DenW + Steps;

    logic [RemW-1:0]  rem_reg  [Steps+1];
    logic [Steps-1:0] quo_reg  [Steps+1];
    logic [DenW-1:0]  den_reg  [Steps+1];
    logic             neg_reg  [Steps+1];
    logic             ovf_reg  [Steps+1];
    logic             wz_reg   [Steps+1];

    logic [DenW-1:0]  num_mag;
    logic [DenW-1:0]  den_mag;
    logic [RemW-1:0]  num_sh;

    logic [hpt_pkg::CoordW-1:0] quo_out_reg;
    logic                       sat_out_reg;
    logic                       wz_out_reg;
    logic [hpt_pkg::CoordW-1:0] quo_next;
    logic                       sat_next;

    // prep stage: magnitudes, sign and the early overflow check
    assign num_mag = num[DenW-1] ? DenW'(-num) : DenW'(num);
    assign den_mag = den[DenW-1] ? DenW'(-den) : DenW'(den);
    assign num_sh  = {num_mag, hpt_pkg::FracW'(0)};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0] <= num_sh;
            quo_reg[0] <= '0;
            den_reg[0] <= den_mag;
            neg_reg[0] <= num[DenW-1] ^ den[DenW-1];
            ovf_reg[0] <= {(PreW - RemW)'(0), num_sh} >= {den_mag, Steps'(0)};
            wz_reg[0]  <= (den == '0);
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam int Sh = Steps - 1 - k;
        logic [CmpW-1:0]  dsh;
        logic             ge;
        logic [Steps-1:0] qn;

        assign dsh = {(CmpW - DenW)'(0), den_reg[k]} << Sh;
        assign ge  = {(CmpW - RemW)'(0), rem_reg[k]} >= dsh;

        always_comb begin
            qn     = quo_reg[k];
            qn[Sh] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                rem_reg[k+1] <= ge ? rem_reg[k] - dsh[RemW-1:0] : rem_reg[k];
                quo_reg[k+1] <= qn;
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                wz_reg[k+1]  <= wz_reg[k];
            end
        end
    end

    // final stage: sign, clamp and the zero-w case
    always_comb begin
        quo_next = '0;
        sat_next = 1'b0;
        if (wz_reg[Steps]) begin
            quo_next = '0;
        end else if (neg_reg[Steps]) begin
            if (ovf_reg[Steps] || quo_reg[Steps] > {1'b0, 1'b1, (Steps-2)'(0)}) begin
                quo_next = {1'b1, (hpt_pkg::CoordW-1)'(0)};
                sat_next = 1'b1;
            end else begin
                quo_next = hpt_pkg::CoordW'(-quo_reg[Steps]);
            end
        end else begin
            if (ovf_reg[Steps] || quo_reg[Steps][Steps-1 -: 2] != 2'b00) begin
                quo_next = {1'b0, {(hpt_pkg::CoordW-1){1'b1}}};
                sat_next = 1'b1;
            end else begin
                quo_next = quo_reg[Steps][hpt_pkg::CoordW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[Steps+1]) begin
            quo_out_reg <= quo_next;
            sat_out_reg <= sat_next;
            wz_out_reg  <= wz_reg[Steps];
        end
    end

    assign quo = quo_out_reg;
    assign sat = sat_out_reg;
    assign wz  = wz_out_reg;

endmodule

// ===== rtl/homogeneous_point_transform_core.sv =====
// channel | dir | tdata (low bit first)   | tuser
// s_      | in  | px, py, pz (96 bits)    | -
// m_      | out | qx, qy, qz (96 bits)    | w_zero, saturated
// cfg_    | in  | cfg_index 4b, cfg_data 64b (matrix registers 0..7)
//
// one item per cycle sustained while m_tready is high; there are two stages for the
// dot products, one prep stage, one stage per quotient bit (33) and one output stage.
// each stage holds its item only while the stage after it is full and stalled, so
// bubbles collapse and input is taken while a result waits.
// aresetn clears the valid bits and loads the identity matrix.
module homogeneous_point_transform_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [3*hpt_pkg::CoordW-1:0]  s_tdata,   // px, py, pz
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [3*hpt_pkg::CoordW-1:0]  m_tdata,   // qx, qy, qz
    output logic [1:0]                    m_tuser,   // w_zero, saturated
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hpt_pkg::IdxW-1:0]      cfg_index,
    input  logic [hpt_pkg::RegW-1:0]      cfg_data
);

    hpt_pkg::mat_t            mat_reg;
    logic [hpt_pkg::NumStg-1:0] valid_reg;
    logic [hpt_pkg::NumStg-1:0] adv;
    hpt_pkg::stg_en_t         stg_en;

    hpt_pkg::sum_t sum_x, sum_y, sum_z, sum_w;
    logic [hpt_pkg::CoordW-1:0] qx, qy, qz;
    logic sat_x, sat_y, sat_z, wz_x, wz_y, wz_z;

    // matrix registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg <= hpt_pkg::MatIdent;
        end else if (cfg_valid && cfg_index < hpt_pkg::IdxW'(hpt_pkg::NumRegs)) begin
            mat_reg[cfg_index[hpt_pkg::IdxW-2:0]] <= cfg_data;
        end
    end

    // per-stage advance: a stage loads when empty or when its successor moves
    always_comb begin
        adv[hpt_pkg::NumStg-1] = !valid_reg[hpt_pkg::NumStg-1] || m_tready;
        for (int i = hpt_pkg::NumStg-2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < hpt_pkg::NumStg; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign stg_en.mul_en = adv[hpt_pkg::MulLen-1:0];
    assign stg_en.div_en = adv[hpt_pkg::NumStg-1:hpt_pkg::MulLen];

    assign s_tready = adv[0];

    hpt_dot u_dot (
        .aclk  (aclk),
        .en    (stg_en.mul_en),
        .mat   (mat_reg),
        .px    (s_tdata[0 +: hpt_pkg::CoordW]),
        .py    (s_tdata[hpt_pkg::CoordW +: hpt_pkg::CoordW]),
        .pz    (s_tdata[2*hpt_pkg::CoordW +: hpt_pkg::CoordW]),
        .sum_x (sum_x),
        .sum_y (sum_y),
        .sum_z (sum_z),
        .sum_w (sum_w)
    );

    hpt_div u_div_x (
        .aclk (aclk), .en (stg_en.div_en), .num (sum_x), .den (sum_w),
        .quo  (qx), .sat (sat_x), .wz (wz_x)
    );

    hpt_div u_div_y (
        .aclk (aclk), .en (stg_en.div_en), .num (sum_y), .den (sum_w),
        .quo  (qy), .sat (sat_y), .wz (wz_y)
    );

    hpt_div u_div_z (
        .aclk (aclk), .en (stg_en.div_en), .num (sum_z), .den (sum_w),
        .quo  (qz), .sat (sat_z), .wz (wz_z)
    );

    // result item
    assign m_tvalid   = valid_reg[hpt_pkg::NumStg-1];
    assign m_tdata    = {qz, qy, qx};
    assign m_tuser[0] = wz_x && wz_y && wz_z;
    assign m_tuser[1] = sat_x || sat_y || sat_z;

endmodule

// ===== rtl/hpt_checker.sv =====
module hpt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // pipeline is empty right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown after reset");

    // zero w forces zero outputs and no clamp
    a_wz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("zero w result not cleared");

    // a clamp shows a limit value in some lane
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
            m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
            m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000)
        else $error("clamp flag without limit value");

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (.*);
